### sv/motion_alarm_qualifier_macros.svh
// ----------------------------------------------------------------------------
// motion alarm qualifier assertion macros
// shared property forms for the qualifier checks
// ----------------------------------------------------------------------------
`ifndef MOTION_ALARM_QUALIFIER_MACROS_SVH
`define MOTION_ALARM_QUALIFIER_MACROS_SVH

// same-cycle implication, held off during reset
`define MAQ_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, held off during reset
`define MAQ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### sv/maq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// maq_pkg
// shared types and constants of the motion alarm qualifier
// ----------------------------------------------------------------------------
package maq_pkg;

  // configuration register indexes
  typedef enum logic [2:0] {
    REG_FRAME_AREA     = 3'd0,
    REG_THRESHOLD      = 3'd1,
    REG_HIT_FRAMES     = 3'd2,
    REG_REGION_ORIGIN  = 3'd3,
    REG_REGION_SIZE    = 3'd4,
    REG_SCHED_DAYS     = 3'd5,
    REG_SCHED_START    = 3'd6,
    REG_SCHED_END      = 3'd7
  } cfg_reg_t;

  localparam int CFG_IDX_BITS  = 3;
  localparam int CFG_DATA_BITS = 32;
  localparam int FRAME_BITS    = 24;
  localparam int PM_BITS       = 10;
  localparam int HITF_BITS     = 8;
  localparam int DAY_BITS      = 7;
  localparam int MIN_BITS      = 11;
  localparam int WDAY_BITS     = 3;
  localparam int COUNT_BITS    = 16;
  localparam int HALF_BITS     = 16;

  // quotient bits produced by the divider, covers 0..2047
  localparam int QUO_BITS = 11;
  localparam int CNT_BITS = $clog2(QUO_BITS);

  localparam logic [PM_BITS-1:0]    PM_SCALE   = 10'd1000;
  localparam logic [PM_BITS-1:0]    PM_MAX     = 10'd1000;
  localparam logic [HITF_BITS-1:0]  STREAK_MAX = 8'hff;
  localparam logic [COUNT_BITS-1:0] COUNT_MAX  = 16'hffff;
  localparam logic [2:0]            SUNDAY_BIT = 3'd6;
  localparam logic [WDAY_BITS-1:0]  WDAY_SUN   = 3'd0;
  localparam logic [WDAY_BITS-1:0]  WDAY_LAST  = 3'd6;

  // controller to datapath commands
  typedef struct packed {
    logic load;    // capture input word
    logic mul;     // scale moving area by 1000
    logic chk;     // overflow check, divider init, window and region checks
    logic step;    // one divider iteration
    logic commit;  // update streak and count, load result word
  } maq_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic saturated;  // quotient known to exceed the per-mille range
    logic div_last;   // final divider iteration in progress
  } maq_status_t;

endpackage

### sv/maq_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// maq_ctrl
// sequencing state machine of the motion alarm qualifier
// ----------------------------------------------------------------------------
module maq_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  input  maq_pkg::maq_status_t status,
  output maq_pkg::maq_cmd_t    cmd
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_CHK,
    ST_DIV,
    ST_FIN
  } state_t;

  state_t state_r;
  state_t state_nxt;
  logic   out_valid_r;
  logic   out_valid_nxt;
  logic   slot_free;

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign slot_free = !out_valid_r || out_ready;

  always_comb begin
    cmd           = '0;
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_ready;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_MUL;
        end
      end
      ST_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = ST_CHK;
      end
      ST_CHK: begin
        cmd.chk   = 1'b1;
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        cmd.step = 1'b1;
        if (status.saturated || status.div_last) begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        if (slot_free) begin
          cmd.commit    = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

### sv/maq_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// maq_dp
// datapath: config registers, per-mille divider, window and region checks,
// streak and alarm counters, result register
// ----------------------------------------------------------------------------
module maq_dp #(
  parameter int COORD_BITS = 12,
  parameter int AREA_BITS  = 24
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [maq_pkg::CFG_IDX_BITS-1:0]    cfg_index,
  input  logic [maq_pkg::CFG_DATA_BITS-1:0]   cfg_data,
  input  logic [AREA_BITS-1:0]                in_motion_area,
  input  logic                                in_box_present,
  input  logic [COORD_BITS-1:0]               in_box_x,
  input  logic [COORD_BITS-1:0]               in_box_y,
  input  logic [COORD_BITS-1:0]               in_box_w,
  input  logic [COORD_BITS-1:0]               in_box_h,
  input  logic [maq_pkg::WDAY_BITS-1:0]       in_weekday,
  input  logic [maq_pkg::MIN_BITS-1:0]        in_minute_of_day,
  input  maq_pkg::maq_cmd_t                   cmd,
  output maq_pkg::maq_status_t                status,
  output logic                                out_alarm,
  output logic [maq_pkg::PM_BITS-1:0]         out_area_per_mille,
  output logic                                out_frame_hit,
  output logic                                out_in_schedule,
  output logic [maq_pkg::HITF_BITS-1:0]       out_streak_now,
  output logic [maq_pkg::COUNT_BITS-1:0]      out_alarm_total
);

  localparam int NW  = AREA_BITS + maq_pkg::PM_BITS;
  localparam int DSW = maq_pkg::FRAME_BITS + maq_pkg::QUO_BITS;
  localparam int CW  = (NW > DSW) ? NW : DSW;
  localparam int SW  = maq_pkg::HALF_BITS + 1;
  localparam int FB  = maq_pkg::FRAME_BITS;
  localparam int QB  = maq_pkg::QUO_BITS;
  localparam int HB  = maq_pkg::HALF_BITS;

  // configuration registers
  logic [FB-1:0]                     frame_area_r;
  logic [maq_pkg::PM_BITS-1:0]       threshold_r;
  logic [maq_pkg::HITF_BITS-1:0]     hit_frames_r;
  logic [maq_pkg::CFG_DATA_BITS-1:0] region_origin_r;
  logic [maq_pkg::CFG_DATA_BITS-1:0] region_size_r;
  logic [maq_pkg::DAY_BITS-1:0]      sched_days_r;
  logic [maq_pkg::MIN_BITS-1:0]      sched_start_r;
  logic [maq_pkg::MIN_BITS-1:0]      sched_end_r;

  // captured input word
  logic [AREA_BITS-1:0]          area_r;
  logic                          present_r;
  logic [COORD_BITS-1:0]         box_x_r;
  logic [COORD_BITS-1:0]         box_y_r;
  logic [COORD_BITS-1:0]         box_w_r;
  logic [COORD_BITS-1:0]         box_h_r;
  logic [maq_pkg::WDAY_BITS-1:0] wday_r;
  logic [maq_pkg::MIN_BITS-1:0]  minute_r;

  // divider state
  logic [NW-1:0]                 num_r;
  logic                          sat_r;
  logic [FB-1:0]                 rem_r;
  logic [QB-1:0]                 nlo_r;
  logic [QB-1:0]                 quo_r;
  logic [maq_pkg::CNT_BITS-1:0]  cnt_r;
  logic                          sched_r;
  logic                          box_ok_r;

  // persistent state
  logic [maq_pkg::HITF_BITS-1:0]  streak_r;
  logic [maq_pkg::COUNT_BITS-1:0] count_r;

  // result register
  logic                           res_alarm_r;
  logic [maq_pkg::PM_BITS-1:0]    res_pm_r;
  logic                           res_hit_r;
  logic                           res_sched_r;
  logic [maq_pkg::HITF_BITS-1:0]  res_streak_r;
  logic [maq_pkg::COUNT_BITS-1:0] res_count_r;

  // combinational
  logic [FB-1:0]                  divisor;
  logic [CW-1:0]                  num_ext;
  logic [CW-1:0]                  den_shift;
  logic [FB:0]                    trial;
  logic [FB:0]                    trial_diff;
  logic                           trial_ge;
  logic [2:0]                     day_sel;
  logic                           day_ok;
  logic                           sched_nxt;
  logic [HB-1:0]                  reg_x, reg_y, reg_w, reg_h;
  logic [SW-1:0]                  lo_x, lo_y, hi_x, hi_y;
  logic [SW-1:0]                  box_rx, box_ry, reg_rx, reg_ry;
  logic                           overlap;
  logic                           box_ok_nxt;
  logic [maq_pkg::PM_BITS-1:0]    pm_val;
  logic                           hit;
  logic [maq_pkg::HITF_BITS-1:0]  streak_inc;
  logic                           fire;
  logic [maq_pkg::HITF_BITS-1:0]  streak_nxt;
  logic [maq_pkg::COUNT_BITS-1:0] count_nxt;

  // zero frame area divides as one
  assign divisor   = (frame_area_r == '0) ? FB'(1) : frame_area_r;
  assign num_ext   = CW'(num_r);
  assign den_shift = CW'({divisor, {QB{1'b0}}});

  // restoring divider step
  assign trial      = {rem_r, nlo_r[QB-1]};
  assign trial_ge   = (trial >= {1'b0, divisor});
  assign trial_diff = trial - {1'b0, divisor};

  assign status.saturated = sat_r;
  assign status.div_last  = (cnt_r == maq_pkg::CNT_BITS'(QB - 1));

  // weekday window
  always_comb begin
    if (wday_r == maq_pkg::WDAY_SUN || wday_r > maq_pkg::WDAY_LAST) begin
      day_sel = maq_pkg::SUNDAY_BIT;
    end else begin
      day_sel = 3'(wday_r - 3'd1);
    end
    day_ok = sched_days_r[day_sel];
    if (!day_ok) begin
      sched_nxt = 1'b0;
    end else if (sched_start_r == sched_end_r) begin
      sched_nxt = 1'b1;
    end else if (sched_start_r < sched_end_r) begin
      sched_nxt = (minute_r >= sched_start_r) && (minute_r < sched_end_r);
    end else begin
      sched_nxt = (minute_r >= sched_start_r) || (minute_r < sched_end_r);
    end
  end

  // region of interest check
  always_comb begin
    reg_x  = region_origin_r[2*HB-1:HB];
    reg_y  = region_origin_r[HB-1:0];
    reg_w  = region_size_r[2*HB-1:HB];
    reg_h  = region_size_r[HB-1:0];
    box_rx = SW'(box_x_r) + SW'(box_w_r);
    box_ry = SW'(box_y_r) + SW'(box_h_r);
    reg_rx = SW'(reg_x) + SW'(reg_w);
    reg_ry = SW'(reg_y) + SW'(reg_h);
    lo_x   = (SW'(box_x_r) > SW'(reg_x)) ? SW'(box_x_r) : SW'(reg_x);
    lo_y   = (SW'(box_y_r) > SW'(reg_y)) ? SW'(box_y_r) : SW'(reg_y);
    hi_x   = (box_rx < reg_rx) ? box_rx : reg_rx;
    hi_y   = (box_ry < reg_ry) ? box_ry : reg_ry;
    overlap    = (hi_x > lo_x) && (hi_y > lo_y);
    box_ok_nxt = (reg_w == '0) || (reg_h == '0) || !present_r ||
                 (box_w_r == '0) || (box_h_r == '0) || overlap;
  end

  // per-mille, hit, streak and alarm count
  always_comb begin
    if (sat_r || (quo_r > QB'(maq_pkg::PM_MAX))) begin
      pm_val = maq_pkg::PM_MAX;
    end else begin
      pm_val = quo_r[maq_pkg::PM_BITS-1:0];
    end
    hit        = (pm_val > threshold_r);
    streak_inc = (streak_r < maq_pkg::STREAK_MAX) ? (streak_r + 8'd1) : streak_r;
    fire       = 1'b0;
    streak_nxt = '0;
    count_nxt  = count_r;
    if (sched_r && hit) begin
      if (streak_inc >= hit_frames_r) begin
        fire = box_ok_r;
        if (box_ok_r && (count_r < maq_pkg::COUNT_MAX)) begin
          count_nxt = count_r + 16'd1;
        end
      end else begin
        streak_nxt = streak_inc;
      end
    end
  end

  // configuration and persistent state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_area_r    <= 24'd307200;
      threshold_r     <= 10'd8;
      hit_frames_r    <= 8'd2;
      region_origin_r <= '0;
      region_size_r   <= '0;
      sched_days_r    <= 7'h7f;
      sched_start_r   <= '0;
      sched_end_r     <= '0;
      streak_r        <= '0;
      count_r         <= '0;
    end else begin
      if (cfg_we) begin
        case (maq_pkg::cfg_reg_t'(cfg_index))
          maq_pkg::REG_FRAME_AREA:    frame_area_r    <= cfg_data[FB-1:0];
          maq_pkg::REG_THRESHOLD:     threshold_r     <= cfg_data[maq_pkg::PM_BITS-1:0];
          maq_pkg::REG_HIT_FRAMES:    hit_frames_r    <= cfg_data[maq_pkg::HITF_BITS-1:0];
          maq_pkg::REG_REGION_ORIGIN: region_origin_r <= cfg_data;
          maq_pkg::REG_REGION_SIZE:   region_size_r   <= cfg_data;
          maq_pkg::REG_SCHED_DAYS:    sched_days_r    <= cfg_data[maq_pkg::DAY_BITS-1:0];
          maq_pkg::REG_SCHED_START:   sched_start_r   <= cfg_data[maq_pkg::MIN_BITS-1:0];
          maq_pkg::REG_SCHED_END:     sched_end_r     <= cfg_data[maq_pkg::MIN_BITS-1:0];
          default: ;
        endcase
      end
      if (cmd.commit) begin
        streak_r <= streak_nxt;
        count_r  <= count_nxt;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      area_r    <= in_motion_area;
      present_r <= in_box_present;
      box_x_r   <= in_box_x;
      box_y_r   <= in_box_y;
      box_w_r   <= in_box_w;
      box_h_r   <= in_box_h;
      wday_r    <= in_weekday;
      minute_r  <= in_minute_of_day;
    end
    if (cmd.mul) begin
      num_r <= NW'(area_r) * NW'(maq_pkg::PM_SCALE);
    end
    if (cmd.chk) begin
      sat_r    <= (num_ext >= den_shift);
      rem_r    <= num_ext[QB +: FB];
      nlo_r    <= num_r[QB-1:0];
      quo_r    <= '0;
      cnt_r    <= '0;
      sched_r  <= sched_nxt;
      box_ok_r <= box_ok_nxt;
    end
    if (cmd.step) begin
      rem_r <= trial_ge ? trial_diff[FB-1:0] : trial[FB-1:0];
      nlo_r <= {nlo_r[QB-2:0], 1'b0};
      quo_r <= {quo_r[QB-2:0], trial_ge};
      cnt_r <= cnt_r + maq_pkg::CNT_BITS'(1);
    end
    if (cmd.commit) begin
      res_alarm_r  <= fire;
      res_pm_r     <= pm_val;
      res_hit_r    <= hit;
      res_sched_r  <= sched_r;
      res_streak_r <= streak_nxt;
      res_count_r  <= count_nxt;
    end
  end

  assign out_alarm          = res_alarm_r;
  assign out_area_per_mille = res_pm_r;
  assign out_frame_hit      = res_hit_r;
  assign out_in_schedule    = res_sched_r;
  assign out_streak_now     = res_streak_r;
  assign out_alarm_total    = res_count_r;

endmodule

### sv/motion_alarm_qualifier.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// motion_alarm_qualifier
// qualifies motion-detector frame results into alarms: per-mille area,
// threshold, weekday/minute window, hit streak and region of interest
// ----------------------------------------------------------------------------
//
//  channel | handshake            | payload
//  --------+----------------------+-------------------------------------------
//  in      | in_valid / in_ready  | motion_area, box_*, weekday, minute_of_day
//  out     | out_valid / out_ready| alarm, area_per_mille, frame_hit,
//          |                      | in_schedule, streak_now, alarm_total
//  cfg     | cfg_we               | cfg_index, cfg_data (write only)
//
//  one word at a time: the next input word waits until the last is committed;
//  the 11-step restoring divider for the per-mille quotient stops early when
//  the scaled area reaches 2048 frame areas and the quotient saturates
//  a finished word sits in the result register while the next input word
//  is taken and worked on; only the final commit waits for that register
//  synchronous active-low reset restores the register defaults and clears
//  the hit streak, the alarm count and the output valid
//
module motion_alarm_qualifier #(
  parameter int COORD_BITS = 12,
  parameter int AREA_BITS  = 24
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // configuration writes
  input  logic                               cfg_we,
  input  logic [maq_pkg::CFG_IDX_BITS-1:0]   cfg_index,
  input  logic [maq_pkg::CFG_DATA_BITS-1:0]  cfg_data,
  // input words
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [AREA_BITS-1:0]               in_motion_area,
  input  logic                               in_box_present,
  input  logic [COORD_BITS-1:0]              in_box_x,
  input  logic [COORD_BITS-1:0]              in_box_y,
  input  logic [COORD_BITS-1:0]              in_box_w,
  input  logic [COORD_BITS-1:0]              in_box_h,
  input  logic [maq_pkg::WDAY_BITS-1:0]      in_weekday,
  input  logic [maq_pkg::MIN_BITS-1:0]       in_minute_of_day,
  // result words
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic                               out_alarm,
  output logic [maq_pkg::PM_BITS-1:0]        out_area_per_mille,
  output logic                               out_frame_hit,
  output logic                               out_in_schedule,
  output logic [maq_pkg::HITF_BITS-1:0]      out_streak_now,
  output logic [maq_pkg::COUNT_BITS-1:0]     out_alarm_total
);

  // command and status between sequencer and datapath
  maq_pkg::maq_cmd_t    cmd;
  maq_pkg::maq_status_t status;

  // sequencer: capture, scale, check, divide, commit
  maq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  // datapath: config registers, divider, checks, counters, result register
  maq_dp #(
    .COORD_BITS (COORD_BITS),
    .AREA_BITS  (AREA_BITS)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .in_motion_area     (in_motion_area),
    .in_box_present     (in_box_present),
    .in_box_x           (in_box_x),
    .in_box_y           (in_box_y),
    .in_box_w           (in_box_w),
    .in_box_h           (in_box_h),
    .in_weekday         (in_weekday),
    .in_minute_of_day   (in_minute_of_day),
    .cmd                (cmd),
    .status             (status),
    .out_alarm          (out_alarm),
    .out_area_per_mille (out_area_per_mille),
    .out_frame_hit      (out_frame_hit),
    .out_in_schedule    (out_in_schedule),
    .out_streak_now     (out_streak_now),
    .out_alarm_total    (out_alarm_total)
  );

  // checks
  `include "motion_alarm_qualifier_macros.svh"

  // one word in flight: accepting a word closes the input until commit
  `MAQ_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_valid && in_ready, !in_ready,
                   "input open while busy")
  // an alarm only comes from an in-schedule hit, and it clears the streak
  `MAQ_ASSERT_NOW(a_alarm_needs_hit, clk, rst_n, out_valid && out_alarm,
                  out_frame_hit && out_in_schedule && (out_streak_now == '0),
                  "alarm without qualified hit")
  // per-mille stays within its saturated range
  `MAQ_ASSERT_NOW(a_pm_range, clk, rst_n, out_valid,
                  out_area_per_mille <= maq_pkg::PM_MAX, "per-mille above 1000")
  // an alarm always leaves a nonzero count
  `MAQ_ASSERT_NOW(a_alarm_counted, clk, rst_n, out_valid && out_alarm,
                  out_alarm_total != '0, "alarm not counted")

endmodule
